### sv/tic_pkg.sv
`timescale 1ns / 1ps

package tic_pkg;

  // Field widths
  localparam int TOKEN_W     = 16;
  localparam int SIZE_W      = 13;
  localparam int CID_W       = 12;
  localparam int COUNT_W     = 13;
  localparam int LIMIT_W     = 17;
  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 16;
  localparam int IN_TUSER_W  = 1;
  localparam int OUT_TUSER_W = 2;

  // Batch tag carried in every map entry
  localparam int EPOCH_W = 8;

  // Defaults
  localparam int                MAX_TOKENS_DEF = 4096;
  localparam logic [SIZE_W-1:0] DICT_SIZE_RST  = 13'd4096;

  // Output tuser bit positions
  localparam int TUSER_IS_NEW = 0;
  localparam int TUSER_OOR    = 1;

  // One map entry: batch tag and dense id
  typedef struct packed {
    logic [EPOCH_W-1:0] epoch;
    logic [CID_W-1:0]   cid;
  } entry_t;

  // Control sequencer
  typedef enum logic {
    ST_CLEAR,
    ST_RUN
  } state_t;

endpackage

### sv/token_id_compaction_unit.sv
`timescale 1ns / 1ps

// Channel   | dir | tdata                   | tuser
// ----------+-----+-------------------------+------------------------------------
// s_axis    | in  | [15:0] token            | [0] batch_start
// m_axis    | out | [11:0] compact_id, pad  | [0] is_new, [1] out_of_range
// cfg_wr    | in  | [12:0] dictionary_size  | -
//
// One beat per cycle in each direction unless m_axis stalls or a clearing pass runs;
// a beat is registered in the input stage, then its result in the result register.
// Reset starts a clearing pass over the map memory; s_axis_tready stays low until it
// finishes. Batches are told apart by an 8-bit tag in each map entry. A batch_start
// beat that arrives with the tag at its last value holds the input stage for another
// clearing pass, i.e. once every 254 batches (255 for the first after reset).
// A stalled m_axis holds the result register; one further beat waits in the input stage.

module token_id_compaction_unit #(
  parameter int MAX_TOKENS = tic_pkg::MAX_TOKENS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  // input beats
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [tic_pkg::IN_TDATA_W-1:0]  s_axis_tdata,   // [15:0] token
  input  logic [tic_pkg::IN_TUSER_W-1:0]  s_axis_tuser,   // [0] batch_start
  // result beats
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [tic_pkg::OUT_TDATA_W-1:0] m_axis_tdata,   // [11:0] compact_id, [15:12] zero
  output logic [tic_pkg::OUT_TUSER_W-1:0] m_axis_tuser,   // [0] is_new, [1] out_of_range
  // configuration
  input  logic                            cfg_wr_en,
  input  logic [tic_pkg::SIZE_W-1:0]      cfg_wr_data     // dictionary_size
);

  localparam int IDX_W   = $clog2(MAX_TOKENS);
  localparam int LW      = tic_pkg::LIMIT_W;
  localparam int EW      = tic_pkg::EPOCH_W;
  localparam int CW      = tic_pkg::CID_W;
  localparam int NW      = tic_pkg::COUNT_W;
  localparam int SW      = tic_pkg::SIZE_W;
  localparam int TW      = tic_pkg::TOKEN_W;
  localparam int PAD_W   = tic_pkg::OUT_TDATA_W - CW;

  localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(MAX_TOKENS - 1);
  localparam logic [LW-1:0]    MAX_LIMIT = LW'(MAX_TOKENS);
  localparam logic [EW-1:0]    EPOCH_MAX = '1;
  localparam logic [EW-1:0]    EPOCH_ONE = EW'(1);
  localparam logic [NW-1:0]    COUNT_MAX = '1;

  // Control state
  tic_pkg::state_t state, state_next;
  logic            clearing;
  logic [IDX_W-1:0] clr_idx;
  logic [EW-1:0]    epoch;
  logic [NW-1:0]    next_compact;
  logic [SW-1:0]    dict_size;

  // Input stage
  logic             a_valid;
  logic [IDX_W-1:0] a_idx;
  logic             a_start;
  logic             a_err;

  // Result register
  logic             r_valid;
  logic [CW-1:0]    r_cid;
  logic             r_new;
  logic             r_err;

  // Map memory and last-write bypass
  tic_pkg::entry_t  map_mem [MAX_TOKENS];
  tic_pkg::entry_t  rd_entry;
  logic             lw_valid;
  logic [IDX_W-1:0] lw_idx;
  tic_pkg::entry_t  lw_entry;

  logic             s_acc;
  logic             a_adv;
  logic [LW-1:0]    limit;
  logic [IDX_W-1:0] raddr;
  logic             we;
  logic [IDX_W-1:0] waddr;
  tic_pkg::entry_t  wdata;

  tic_pkg::entry_t  ent;
  logic [EW-1:0]    epoch_eff;
  logic [NW-1:0]    next_base;
  logic [NW-1:0]    next_upd;
  logic             hit;
  logic             wr_item;
  logic [CW-1:0]    res_cid;
  logic             res_new;

  // Sequencer: next state
  always_comb begin
    state_next = state;
    unique case (state)
      tic_pkg::ST_CLEAR: begin
        if (clr_idx == LAST_IDX) state_next = tic_pkg::ST_RUN;
      end
      tic_pkg::ST_RUN: begin
        if (a_valid && a_start && (epoch == EPOCH_MAX)) state_next = tic_pkg::ST_CLEAR;
      end
      default: state_next = tic_pkg::ST_CLEAR;
    endcase
  end

  // Sequencer: outputs
  always_comb begin
    unique case (state)
      tic_pkg::ST_CLEAR: clearing = 1'b1;
      tic_pkg::ST_RUN:   clearing = 1'b0;
      default:           clearing = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tic_pkg::ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // Handshakes
  assign a_adv = a_valid && !clearing && !(a_start && (epoch == EPOCH_MAX))
                 && (!r_valid || m_axis_tready);
  assign s_axis_tready = !clearing && (!a_valid || a_adv);
  assign s_acc = s_axis_tvalid && s_axis_tready;

  // Usable size: smaller of dictionary_size and the map depth
  assign limit = ({{(LW-SW){1'b0}}, dict_size} > MAX_LIMIT) ? MAX_LIMIT
               : {{(LW-SW){1'b0}}, dict_size};

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      dict_size <= tic_pkg::DICT_SIZE_RST;
    end else if (cfg_wr_en) begin
      dict_size <= cfg_wr_data;
    end
  end

  // Input stage
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (s_acc) begin
      a_valid <= 1'b1;
    end else if (a_adv) begin
      a_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_acc) begin
      a_idx   <= s_axis_tdata[IDX_W-1:0];
      a_start <= s_axis_tuser[0];
      a_err   <= {{(LW-TW){1'b0}}, s_axis_tdata[TW-1:0]} >= limit;
    end
  end

  // Map memory: read follows the beat entering or held in the input stage
  assign raddr = s_acc ? s_axis_tdata[IDX_W-1:0] : a_idx;

  always_ff @(posedge clk) begin
    if (we) map_mem[waddr] <= wdata;
    rd_entry <= map_mem[raddr];
  end

  // Lookup and update for the beat in the input stage
  always_comb begin
    ent       = (lw_valid && (lw_idx == a_idx)) ? lw_entry : rd_entry;
    epoch_eff = a_start ? epoch + EPOCH_ONE : epoch;
    next_base = a_start ? '0 : next_compact;
    hit       = !a_start && (ent.epoch == epoch);
    res_cid   = '0;
    res_new   = 1'b0;
    wr_item   = 1'b0;
    next_upd  = next_base;
    if (!a_err) begin
      if (hit) begin
        res_cid = ent.cid;
      end else begin
        res_cid = next_base[CW-1:0];
        res_new = 1'b1;
        wr_item = 1'b1;
        if (next_base != COUNT_MAX) next_upd = next_base + NW'(1);
      end
    end
  end

  // Write port: clearing sweep or the item's new entry
  always_comb begin
    if (clearing) begin
      we    = 1'b1;
      waddr = clr_idx;
      wdata = '0;
    end else begin
      we          = a_adv && wr_item;
      waddr       = a_idx;
      wdata.epoch = epoch_eff;
      wdata.cid   = res_cid;
    end
  end

  // Last write, for a read that raced it
  always_ff @(posedge clk) begin
    if (rst) begin
      lw_valid <= 1'b0;
    end else if (clearing) begin
      lw_valid <= 1'b0;
    end else if (a_adv && wr_item) begin
      lw_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (a_adv && wr_item) begin
      lw_idx   <= a_idx;
      lw_entry <= wdata;
    end
  end

  // Sweep index, batch tag and id counter
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_idx      <= '0;
      epoch        <= EPOCH_ONE;
      next_compact <= '0;
    end else if (clearing) begin
      if (clr_idx == LAST_IDX) begin
        clr_idx <= '0;
        epoch   <= EPOCH_ONE;
      end else begin
        clr_idx <= clr_idx + IDX_W'(1);
      end
    end else if (a_adv) begin
      epoch        <= epoch_eff;
      next_compact <= next_upd;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      r_valid <= 1'b0;
    end else if (a_adv) begin
      r_valid <= 1'b1;
    end else if (m_axis_tready) begin
      r_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (a_adv) begin
      r_cid <= res_cid;
      r_new <= res_new;
      r_err <= a_err;
    end
  end

  assign m_axis_tvalid = r_valid;
  assign m_axis_tdata  = {{PAD_W{1'b0}}, r_cid};
  always_comb begin
    m_axis_tuser                       = '0;
    m_axis_tuser[tic_pkg::TUSER_IS_NEW] = r_new;
    m_axis_tuser[tic_pkg::TUSER_OOR]    = r_err;
  end

endmodule

### sv/tic_checker.sv
`timescale 1ns / 1ps

module tic_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            s_axis_tready,
  input logic                            m_axis_tvalid,
  input logic                            m_axis_tready,
  input logic [tic_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  input logic [tic_pkg::OUT_TUSER_W-1:0] m_axis_tuser
);

  // Reset starts the clearing pass: no input taken, no result shown
  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !s_axis_tready && !m_axis_tvalid)
    else $error("beat taken or result shown straight after reset");

  // An out-of-range result carries id zero and is never new
  a_oor_result: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser[tic_pkg::TUSER_OOR]
      |-> (m_axis_tdata == '0) && !m_axis_tuser[tic_pkg::TUSER_IS_NEW])
    else $error("out-of-range result with non-zero id or new flag");

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready
      |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result changed or dropped while stalled");

  // A result only leaves when taken
  a_out_leave: assert property (@(posedge clk) disable iff (rst)
    $fell(m_axis_tvalid) |-> $past(m_axis_tready))
    else $error("result withdrawn without being taken");

endmodule

bind token_id_compaction_unit tic_checker u_tic_checker (.*);

### tb/token_id_compaction_unit_tb.sv
`timescale 1ns / 1ps

module token_id_compaction_unit_tb;

  localparam int MAP_DEPTH     = tic_pkg::MAX_TOKENS_DEF;
  localparam int IDX_W         = $clog2(MAP_DEPTH);
  localparam int TW            = tic_pkg::TOKEN_W;
  localparam int SW            = tic_pkg::SIZE_W;
  localparam int NW            = tic_pkg::COUNT_W;
  localparam int CW            = tic_pkg::CID_W;
  localparam int FULL_IDS      = 512;    // distinct ids in the long batch
  localparam int TAG_BATCHES   = 260;    // enough to roll the batch tag over
  localparam int RANDOM_ITEMS  = 800;
  localparam int STALL_LIMIT   = 20000;  // covers a full clearing pass plus stalls
  localparam int SETTLE_CYCLES = 8;
  localparam int IDLE_PCT      = 29;

  // Expected fields of one result beat
  typedef struct packed {
    logic [CW-1:0] cid;
    logic          is_new;
    logic          oor;
  } token_result_t;

  logic                            clk = 1'b0;
  logic                            rst = 1'b1;
  logic                            s_axis_tvalid = 1'b0;
  logic                            s_axis_tready;
  logic [tic_pkg::IN_TDATA_W-1:0]  s_axis_tdata = '0;
  logic [tic_pkg::IN_TUSER_W-1:0]  s_axis_tuser = '0;
  logic                            m_axis_tvalid;
  logic                            m_axis_tready = 1'b0;
  logic [tic_pkg::OUT_TDATA_W-1:0] m_axis_tdata;
  logic [tic_pkg::OUT_TUSER_W-1:0] m_axis_tuser;
  logic                            cfg_wr_en = 1'b0;
  logic [SW-1:0]                   cfg_wr_data = '0;

  // Shadow of the renumbering state
  logic [MAP_DEPTH-1:0] seen_map;
  logic [CW-1:0]        cid_map [MAP_DEPTH];
  logic [NW-1:0]        next_cid;
  logic [SW-1:0]        dict_size;

  token_result_t expected_results [$];

  bit calm = 1'b0;  // both sides stream without idling
  int n_tokens = 0;
  int n_batches = 0;
  int n_new = 0;
  int n_oor = 0;
  int n_fail = 0;
  int stall_cycles = 0;

  token_id_compaction_unit dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),   // [15:0] token
    .s_axis_tuser  (s_axis_tuser),   // [0] batch_start
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),   // [11:0] compact_id, [15:12] zero
    .m_axis_tuser  (m_axis_tuser),   // [0] is_new, [1] out_of_range
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data)     // dictionary_size
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Renumber one token against the shadow map
  function automatic token_result_t renumber_token(input logic [TW-1:0] tok,
                                                   input logic start);
    token_result_t r;
    int lim;
    logic [IDX_W-1:0] idx;
    r = '0;
    idx = tok[IDX_W-1:0];
    if (start) begin
      seen_map = '0;
      next_cid = '0;
    end
    lim = (int'(dict_size) > MAP_DEPTH) ? MAP_DEPTH : int'(dict_size);
    if (int'(tok) >= lim) begin
      r.oor = 1'b1;
    end else begin
      if (!seen_map[idx]) begin
        seen_map[idx] = 1'b1;
        cid_map[idx] = next_cid[CW-1:0];
        if (next_cid != '1) next_cid = next_cid + NW'(1);
        r.is_new = 1'b1;
      end
      r.cid = cid_map[idx];
    end
    return r;
  endfunction

  // Random gap length, about IDLE_PCT percent of cycles
  function automatic int idle_gap();
    int n;
    n = 0;
    if (!calm) begin
      while ($urandom_range(99) < IDLE_PCT) n++;
    end
    return n;
  endfunction

  // Send one token beat; predict once it is taken
  task automatic send_token(input logic [TW-1:0] tok, input logic start);
    int gap;
    gap = idle_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= tok;
    s_axis_tuser  <= start;
    do @(posedge clk); while (!s_axis_tready);
    expected_results.push_back(renumber_token(tok, start));
    n_tokens++;
    if (start) n_batches++;
  endtask

  // Stop sending, let every result drain and the pipeline settle
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_dict_size(input logic [SW-1:0] sz);
    wait_idle();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= sz;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    dict_size = sz;
  endtask

  // Edges at the reset size: id extremes, repeats, clear on an error beat
  task automatic test_reset_edges();
    send_token(16'd0, 1'b1);
    send_token(16'd0, 1'b0);
    send_token(16'd4095, 1'b0);
    send_token(16'd4096, 1'b0);
    send_token(16'hFFFF, 1'b0);
    send_token(16'd4095, 1'b0);
    send_token(16'd5000, 1'b1);   // out of range, clear still happens
    send_token(16'd4095, 1'b0);
    send_token(16'h0AAA, 1'b0);
    send_token(16'h0555, 1'b0);
  endtask

  // Dictionary size extremes; a write keeps the current map
  task automatic test_size_extremes();
    write_dict_size('0);
    send_token(16'd0, 1'b1);
    send_token(16'd0, 1'b0);
    write_dict_size(13'd1);
    send_token(16'd0, 1'b1);
    send_token(16'd0, 1'b0);
    send_token(16'd1, 1'b0);
    write_dict_size('1);          // above range, capped by the map depth
    send_token(16'd4095, 1'b1);
    send_token(16'd4096, 1'b0);
    send_token(16'd8190, 1'b0);
    send_token(16'd0, 1'b0);
    write_dict_size(13'd4095);
    send_token(16'd4094, 1'b0);
    send_token(16'd4095, 1'b0);
    send_token(16'd0, 1'b0);
  endtask

  // One long batch of distinct ids drawn from the whole map, then repeats
  task automatic test_full_dictionary();
    int perm [MAP_DEPTH];
    int j, t;
    write_dict_size(tic_pkg::DICT_SIZE_RST);
    for (int i = 0; i < MAP_DEPTH; i++) perm[i] = i;
    for (int i = MAP_DEPTH - 1; i > 0; i--) begin
      j = $urandom_range(i);
      t = perm[i];
      perm[i] = perm[j];
      perm[j] = t;
    end
    for (int i = 0; i < FULL_IDS; i++) send_token(TW'(perm[i]), i == 0);
    for (int i = 0; i < 20; i++) send_token(TW'(perm[$urandom_range(FULL_IDS - 1)]), 1'b0);
    send_token(TW'(MAP_DEPTH), 1'b0);
  endtask

  // Enough short batches to roll the batch tag over
  task automatic test_tag_wrap();
    int blen;
    write_dict_size(13'd32);
    for (int b = 0; b < TAG_BATCHES; b++) begin
      blen = $urandom_range(2, 1);
      for (int i = 0; i < blen; i++) send_token(TW'($urandom_range(39)), i == 0);
    end
  endtask

  // Random batches over a rotation of dictionary sizes
  task automatic test_random_batches(input int n_items);
    int sent, phase_sent, blen, hot, r, k;
    int lim;
    logic [SW-1:0] sz;
    logic [TW-1:0] tok;
    logic start;
    sent = 0;
    k = 0;
    while (sent < n_items) begin
      case (k % 6)
        0:       sz = SW'($urandom_range(64, 1));
        1:       sz = tic_pkg::DICT_SIZE_RST;
        2:       sz = SW'($urandom_range(700, 65));
        3:       sz = '1;
        4:       sz = SW'($urandom_range(8));
        default: sz = SW'($urandom_range(8191));
      endcase
      write_dict_size(sz);
      calm = (k == 2);
      lim = (int'(sz) > MAP_DEPTH) ? MAP_DEPTH : int'(sz);
      phase_sent = 0;
      while (phase_sent < 150 && sent < n_items) begin
        blen = ($urandom_range(9) == 0) ? $urandom_range(200, 41) : $urandom_range(40, 1);
        hot = (lim > 0) ? int'($urandom_range(lim, 1)) : 1;
        for (int i = 0; i < blen; i++) begin
          // mostly well-formed: batch_start only on the first beat
          start = (i == 0) || ($urandom_range(49) == 0);
          r = $urandom_range(99);
          if (r < 80 && lim > 0) tok = TW'($urandom_range(hot - 1));
          else if (r < 90) tok = TW'($urandom);
          else tok = (lim == 0) ? TW'($urandom_range(1))
                                : TW'(lim - 1 + int'($urandom_range(1)));
          send_token(tok, start);
          sent++;
          phase_sent++;
        end
      end
      k++;
    end
    calm = 1'b0;
  endtask

  // Result checking, receiver stalls and watchdog
  always @(posedge clk) begin
    token_result_t want;
    m_axis_tready <= calm || ($urandom_range(99) >= IDLE_PCT);
    if (m_axis_tvalid && m_axis_tready) begin
      stall_cycles = 0;
      if (expected_results.size() == 0) begin
        $error("result beat with nothing pending: tdata %h tuser %b", m_axis_tdata,
               m_axis_tuser);
        n_fail++;
      end else begin
        want = expected_results.pop_front();
        if (m_axis_tdata[CW-1:0] !== want.cid) begin
          $error("compact_id: expected %0d, got %0d", want.cid, m_axis_tdata[CW-1:0]);
          n_fail++;
        end
        if (m_axis_tdata[tic_pkg::OUT_TDATA_W-1:CW] !== '0) begin
          $error("tdata pad: expected 0, got %h", m_axis_tdata[tic_pkg::OUT_TDATA_W-1:CW]);
          n_fail++;
        end
        if (m_axis_tuser[tic_pkg::TUSER_IS_NEW] !== want.is_new) begin
          $error("is_new: expected %b, got %b", want.is_new,
                 m_axis_tuser[tic_pkg::TUSER_IS_NEW]);
          n_fail++;
        end
        if (m_axis_tuser[tic_pkg::TUSER_OOR] !== want.oor) begin
          $error("out_of_range: expected %b, got %b", want.oor,
                 m_axis_tuser[tic_pkg::TUSER_OOR]);
          n_fail++;
        end
        if (want.is_new) n_new++;
        if (want.oor) n_oor++;
      end
    end else if (s_axis_tvalid && s_axis_tready) begin
      stall_cycles = 0;
    end else if (!rst) begin
      stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("watchdog: no beat for %0d cycles, %0d results outstanding", stall_cycles,
                 expected_results.size());
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  initial begin
    seen_map  = '0;
    next_cid  = '0;
    dict_size = tic_pkg::DICT_SIZE_RST;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    test_reset_edges();
    test_size_extremes();
    test_full_dictionary();
    test_tag_wrap();
    test_random_batches(RANDOM_ITEMS);
    wait_idle();

    $display("Covered %0d tokens in %0d batches: %0d new ids, %0d out of range.", n_tokens,
             n_batches, n_new, n_oor);
    $display("Sizes 0 to 8191, a 512-id batch over the whole id range, batch tag roll-over,");
    $display("random stalls on both sides.");
    if (n_fail == 0 && expected_results.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

### token_id_compaction_unit.f
sv/tic_pkg.sv
sv/token_id_compaction_unit.sv
sv/tic_checker.sv
tb/token_id_compaction_unit_tb.sv
